[sv/deq_pkg.sv]
// Deque engine package: sizes, request and status codes, RAM request struct
// and the circular slot helper. No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned DOUT_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned MATCH_W  = 5;

  // wide enough for head + offset and for position/count compares
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

  localparam logic [FUNC_W-1:0] FN_PUSH_TAIL = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_HEAD = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_HEAD  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_TAIL  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DELETE    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ      = 3'd5;
  localparam logic [FUNC_W-1:0] FN_COUNT     = 3'd6;
  localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } ram_req_t;

  // physical slot of logical offset from the head, offset below 2*DEPTH - head
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CMP_W-1:0] off);
    logic [CMP_W-1:0] sum;
    sum = CMP_W'(head) + off;
    if (sum >= CMP_W'(DEPTH)) begin
      sum = sum - CMP_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

[sv/deq_ram.sv]
// Entry store of the deque: one write port, one read port, registered read.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_ram (
  input  logic                                clk_i,
  input  deq_pkg::ram_req_t                   req_i,
  output logic [deq_pkg::DATA_WIDTH-1:0]      rdata_o
);
  import deq_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/double_ended_queue_engine.sv]
// Deque engine top level: request sequencer, head/count state, output register.
// Depends on deq_pkg and deq_ram.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------------
//   request | in        | in_valid_i / in_ready_o | func_i, value_i, position_i
//   result  | out       | out_valid_o/out_ready_i | data_out_o, status_o, occupancy_o,
//           |           |                         | match_count_o
//
// One request at a time; in_ready_o is high only while the sequencer is idle.
// Push, clear and failing requests go from idle straight to S_RES; pop and read pass S_LOAD.
// Delete at position p passes S_DEL, then S_SHIFT moves each later entry, one per cycle
// through the single store port pair. Count walks S_CNT, one compare per cycle.
// Reset (rst_ni low, asynchronous) empties the deque; store contents are not cleared.
// A stalled result holds; the next request is taken while it waits.
`timescale 1ns / 1ps

module double_ended_queue_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [deq_pkg::FUNC_W-1:0]        func_i,
  input  logic [deq_pkg::VALUE_W-1:0]       value_i,
  input  logic [deq_pkg::POS_W-1:0]         position_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [deq_pkg::DOUT_W-1:0]        data_out_o,
  output logic [deq_pkg::STATUS_W-1:0]      status_o,
  output logic [deq_pkg::OCC_W-1:0]         occupancy_o,
  output logic [deq_pkg::MATCH_W-1:0]       match_count_o
);
  import deq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DEL   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_CNT   = 3'd4;
  localparam logic [2:0] S_RES   = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [CNT_W-1:0]      match_q, match_d;
  logic [DOUT_W-1:0]     data_q, data_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [DATA_WIDTH-1:0] value_q, value_d;

  logic                  ov_q, ov_d;
  logic [DOUT_W-1:0]     odata_q, odata_d;
  logic [STATUS_W-1:0]   ostatus_q, ostatus_d;
  logic [OCC_W-1:0]      oocc_q, oocc_d;
  logic [MATCH_W-1:0]    omatch_q, omatch_d;

  ram_req_t              req;
  logic [DATA_WIDTH-1:0] rdata;
  logic [CMP_W-1:0]      pos_w, cnt_w, idx_w;
  logic                  accept;

  deq_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign pos_w  = CMP_W'(position_i);
  assign cnt_w  = CMP_W'(count_q);
  assign idx_w  = CMP_W'(idx_q);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    match_d   = match_q;
    data_d    = data_q;
    status_d  = status_q;
    value_d   = value_q;
    ov_d      = ov_q;
    odata_d   = odata_q;
    ostatus_d = ostatus_q;
    oocc_d    = oocc_q;
    omatch_d  = omatch_q;
    req       = '0;

    if (out_ready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          value_d  = DATA_WIDTH'(value_i);
          data_d   = '0;
          status_d = ST_OK;
          match_d  = '0;
          state_d  = S_RES;
          case (func_i)
            FN_PUSH_TAIL: begin
              if (cnt_w == CMP_W'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                req.we    = 1'b1;
                req.waddr = slot_of(head_q, cnt_w);
                req.wdata = DATA_WIDTH'(value_i);
                count_d   = count_q + 1'b1;
              end
            end
            FN_PUSH_HEAD: begin
              if (cnt_w == CMP_W'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                req.we    = 1'b1;
                req.waddr = slot_of(head_q, CMP_W'(DEPTH - 1));
                req.wdata = DATA_WIDTH'(value_i);
                head_d    = slot_of(head_q, CMP_W'(DEPTH - 1));
                count_d   = count_q + 1'b1;
              end
            end
            FN_POP_HEAD: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                req.re    = 1'b1;
                req.raddr = head_q;
                head_d    = slot_of(head_q, CMP_W'(1));
                count_d   = count_q - 1'b1;
                state_d   = S_LOAD;
              end
            end
            FN_POP_TAIL: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                req.re    = 1'b1;
                req.raddr = slot_of(head_q, cnt_w - CMP_W'(1));
                count_d   = count_q - 1'b1;
                state_d   = S_LOAD;
              end
            end
            FN_DELETE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else if (pos_w == '0 || pos_w > cnt_w) begin
                status_d = ST_BADPOS;
              end else begin
                req.re    = 1'b1;
                req.raddr = slot_of(head_q, pos_w - CMP_W'(1));
                idx_d     = CNT_W'(pos_w - CMP_W'(1));
                state_d   = S_DEL;
              end
            end
            FN_READ: begin
              if (pos_w >= cnt_w) begin
                status_d = ST_BADPOS;
              end else begin
                req.re    = 1'b1;
                req.raddr = slot_of(head_q, pos_w);
                state_d   = S_LOAD;
              end
            end
            FN_COUNT: begin
              if (count_q != '0) begin
                req.re    = 1'b1;
                req.raddr = head_q;
                idx_d     = '0;
                state_d   = S_CNT;
              end
            end
            FN_CLEAR: begin
              head_d  = '0;
              count_d = '0;
            end
            default: begin
              state_d = S_RES;
            end
          endcase
        end
      end
      S_LOAD: begin
        data_d  = DOUT_W'(rdata);
        state_d = S_RES;
      end
      S_DEL: begin
        data_d = DOUT_W'(rdata);
        if (idx_w + CMP_W'(1) < cnt_w) begin
          req.re    = 1'b1;
          req.raddr = slot_of(head_q, idx_w + CMP_W'(1));
          state_d   = S_SHIFT;
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_RES;
        end
      end
      S_SHIFT: begin
        // write back the entry fetched last cycle, fetch the one after
        req.we    = 1'b1;
        req.waddr = slot_of(head_q, idx_w);
        req.wdata = rdata;
        idx_d     = idx_q + 1'b1;
        if (idx_w + CMP_W'(2) < cnt_w) begin
          req.re    = 1'b1;
          req.raddr = slot_of(head_q, idx_w + CMP_W'(2));
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_RES;
        end
      end
      S_CNT: begin
        if (rdata == value_q) begin
          match_d = match_q + 1'b1;
        end
        if (idx_w + CMP_W'(1) < cnt_w) begin
          req.re    = 1'b1;
          req.raddr = slot_of(head_q, idx_w + CMP_W'(1));
          idx_d     = idx_q + 1'b1;
        end else begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (!ov_q || out_ready_i) begin
          ov_d      = 1'b1;
          odata_d   = data_q;
          ostatus_d = status_q;
          oocc_d    = OCC_W'(count_q);
          omatch_d  = MATCH_W'(match_q);
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_q   <= match_d;
    data_q    <= data_d;
    status_q  <= status_d;
    value_q   <= value_d;
    odata_q   <= odata_d;
    ostatus_q <= ostatus_d;
    oocc_q    <= oocc_d;
    omatch_q  <= omatch_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = ov_q;
  assign data_out_o    = odata_q;
  assign status_o      = ostatus_q;
  assign occupancy_o   = oocc_q;
  assign match_count_o = omatch_q;

endmodule
